// File: rtl/swe_pkg.sv
// ----------------------------------------------------------------------------
// swe_pkg
// Types, codes and constants shared by the single-wire EEPROM slave files.
// ----------------------------------------------------------------------------
package swe_pkg;

  localparam int unsigned MemDepth = 128;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned DurW     = 20;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [3:0] OpcodeEeprom = 4'hA;
  localparam logic [7:0] EraseByte    = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgStartHighMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgResetLowMin  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOneLowMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOneLowMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZeroLowMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroLowMax   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgChipAddress  = 3'd6;

  localparam logic [DurW-1:0] StartHighMinRst = 20'd84000;
  localparam logic [DurW-1:0] ResetLowMinRst  = 20'd25200;
  localparam logic [DurW-1:0] OneLowMinRst    = 20'd168;
  localparam logic [DurW-1:0] OneLowMaxRst    = 20'd336;
  localparam logic [DurW-1:0] ZeroLowMinRst   = 20'd1008;
  localparam logic [DurW-1:0] ZeroLowMaxRst   = 20'd2688;

  localparam logic [2:0] HoldNone = 3'd0;
  localparam logic [2:0] HoldBit  = 3'd1;
  localparam logic [2:0] HoldAck  = 3'd2;
  localparam logic [2:0] HoldDisc = 3'd6;

  localparam logic [2:0] BusReset = 3'd0;
  localparam logic [2:0] BusDisc  = 3'd1;
  localparam logic [2:0] BusIdle  = 3'd2;
  localparam logic [2:0] BusDin   = 3'd3;
  localparam logic [2:0] BusDout  = 3'd4;

  typedef enum logic [4:0] {
    ModeReset = 5'b00001,
    ModeDisc  = 5'b00010,
    ModeIdle  = 5'b00100,
    ModeDin   = 5'b01000,
    ModeDout  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic level;
    logic gt_start;
    logic gt_reset;
    logic one;
    logic zero;
  } edge_info_t;

  function automatic logic [2:0] bus_code(input mode_e m);
    logic [2:0] c;
    unique case (m)
      ModeReset: c = BusReset;
      ModeDisc:  c = BusDisc;
      ModeIdle:  c = BusIdle;
      ModeDin:   c = BusDin;
      ModeDout:  c = BusDout;
      default:   c = BusReset;
    endcase
    return c;
  endfunction

  function automatic logic [AddrW-1:0] ptr_next(input logic [AddrW-1:0] p);
    return (p == AddrW'(MemDepth - 1)) ? '0 : p + AddrW'(1);
  endfunction

endpackage

// File: rtl/single_wire_eeprom_slave.sv
// Results: an accepted item is captured in the edge register, then its
// result in the result register, which waits while the output is stalled;
// one item is accepted every cycle while the output is not stalled.
// Throughput is set by the single state-update stage, which also keeps the
// RAM read ahead at the next address pointer.
// Reset: timing registers take their defaults, bus mode is reset, and 128
// valid bits make every byte read as 0xFF until written; no clearing pass.
// ----------------------------------------------------------------------------
// single_wire_eeprom_slave
// Slave side of a single-wire EEPROM bus: pulse decoding, byte handling,
// ACK/NACK and read-out of a 128-byte store.
// ----------------------------------------------------------------------------
module single_wire_eeprom_slave import swe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               new_level_i,
  input  logic [DurW-1:0]    duration_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drive_o,
  output logic               drive_level_o,
  output logic [2:0]         hold_us_o,
  output logic [2:0]         bus_mode_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_data_i
);

  logic [DurW-1:0] start_high_min_q, reset_low_min_q, one_low_min_q, one_low_max_q;
  logic [DurW-1:0] zero_low_min_q, zero_low_max_q;
  logic [2:0]      chip_address_q;

  logic       s1_valid_q;
  edge_info_t s1_q, s1_d;
  logic       proc;

  mode_e            mode_q, mode_d;
  logic [3:0]       bit_count_q, bit_count_d;
  logic [7:0]       shift_in_q, shift_in_d;
  logic [7:0]       shift_out_q, shift_out_d;
  logic [1:0]       byte_index_q, byte_index_d;
  logic [3:0]       opcode_q, opcode_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [MemDepth-1:0] mem_valid_q;
  logic             rvalid_q;

  logic             mem_we;
  logic [7:0]       mem_rdata;
  logic [7:0]       rd_byte;

  logic       out_valid_q;
  logic       drive_q, drive_d;
  logic       dlev_q, dlev_d;
  logic [2:0] hold_q, hold_d;
  logic [2:0] bus_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_high_min_q <= StartHighMinRst;
      reset_low_min_q  <= ResetLowMinRst;
      one_low_min_q    <= OneLowMinRst;
      one_low_max_q    <= OneLowMaxRst;
      zero_low_min_q   <= ZeroLowMinRst;
      zero_low_max_q   <= ZeroLowMaxRst;
      chip_address_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStartHighMin: start_high_min_q <= cfg_data_i;
        CfgResetLowMin:  reset_low_min_q  <= cfg_data_i;
        CfgOneLowMin:    one_low_min_q    <= cfg_data_i;
        CfgOneLowMax:    one_low_max_q    <= cfg_data_i;
        CfgZeroLowMin:   zero_low_min_q   <= cfg_data_i;
        CfgZeroLowMax:   zero_low_max_q   <= cfg_data_i;
        CfgChipAddress:  chip_address_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Classify the pulse on entry
  always_comb begin
    s1_d.level    = new_level_i;
    s1_d.gt_start = duration_i > start_high_min_q;
    s1_d.gt_reset = duration_i > reset_low_min_q;
    s1_d.one      = (duration_i > one_low_min_q) && (duration_i < one_low_max_q);
    s1_d.zero     = (duration_i > zero_low_min_q) && (duration_i < zero_low_max_q);
  end

  assign proc       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= s1_d;
    end
  end

  assign rd_byte = rvalid_q ? mem_rdata : EraseByte;

  always_comb begin
    logic [3:0] bc;
    logic [7:0] si;
    logic [1:0] bi;
    logic [7:0] so;
    logic       ack;
    mode_d       = mode_q;
    bit_count_d  = bit_count_q;
    shift_in_d   = shift_in_q;
    shift_out_d  = shift_out_q;
    byte_index_d = byte_index_q;
    opcode_d     = opcode_q;
    ptr_d        = ptr_q;
    mem_we       = 1'b0;
    drive_d      = 1'b0;
    dlev_d       = 1'b1;
    hold_d       = HoldNone;
    bc           = bit_count_q;
    si           = shift_in_q;
    bi           = byte_index_q;
    so           = shift_out_q;
    ack          = 1'b0;
    if (proc) begin
      if (!s1_q.level) begin
        if (s1_q.gt_start) begin
          mode_d = ModeIdle;
        end
      end else if (s1_q.gt_reset) begin
        bit_count_d = '0;
        shift_in_d  = '0;
        mode_d      = ModeDisc;
      end else begin
        unique case (mode_q)
          ModeDisc: begin
            if (s1_q.one) begin
              drive_d = 1'b1;
              dlev_d  = 1'b0;
              hold_d  = HoldDisc;
              mode_d  = ModeIdle;
            end
          end
          ModeIdle, ModeDin: begin
            if (mode_q == ModeIdle) begin
              bc          = '0;
              si          = '0;
              bi          = '0;
              opcode_d    = '0;
              shift_out_d = '0;
              mode_d      = ModeDin;
            end
            bit_count_d  = bc;
            shift_in_d   = si;
            byte_index_d = bi;
            if ((s1_q.one || s1_q.zero) && (bc < 4'd8)) begin
              shift_in_d  = {si[6:0], s1_q.one};
              bit_count_d = bc + 4'd1;
            end else if (bc == 4'd8) begin
              if (bi == 2'd0) begin
                opcode_d = si[7:4];
                if (si[3:1] == chip_address_q) begin
                  if (si[0]) begin
                    mode_d = ModeDout;
                  end
                  if (si[7:4] == OpcodeEeprom) begin
                    byte_index_d = 2'd1;
                    ack          = 1'b1;
                  end
                end
              end else if (bi == 2'd1) begin
                if ({24'd0, si} < 32'(MemDepth)) begin
                  ptr_d        = AddrW'(si);
                  byte_index_d = 2'd2;
                  ack          = 1'b1;
                end
              end else begin
                mem_we = 1'b1;
                ptr_d  = ptr_next(ptr_q);
                ack    = 1'b1;
              end
              shift_in_d  = '0;
              drive_d     = 1'b1;
              dlev_d      = !ack;
              hold_d      = HoldAck;
              bit_count_d = '0;
            end
          end
          ModeDout: begin
            if (bc < 4'd8) begin
              if ((bc == 4'd0) && (opcode_q == OpcodeEeprom)) begin
                so    = rd_byte;
                ptr_d = ptr_next(ptr_q);
              end
              drive_d     = 1'b1;
              dlev_d      = so[7];
              hold_d      = HoldBit;
              bit_count_d = bc + 4'd1;
              shift_out_d = {so[6:0], 1'b0};
            end else if (bc == 4'd8) begin
              if (s1_q.one) begin
                mode_d = ModeIdle;
              end
              bit_count_d = '0;
            end
          end
          ModeReset: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeReset;
      bit_count_q  <= '0;
      shift_in_q   <= '0;
      shift_out_q  <= '0;
      byte_index_q <= '0;
      opcode_q     <= '0;
      ptr_q        <= '0;
      mem_valid_q  <= '0;
      rvalid_q     <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      bit_count_q  <= bit_count_d;
      shift_in_q   <= shift_in_d;
      shift_out_q  <= shift_out_d;
      byte_index_q <= byte_index_d;
      opcode_q     <= opcode_d;
      ptr_q        <= ptr_d;
      rvalid_q     <= mem_valid_q[ptr_d];
      if (mem_we) begin
        mem_valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  // Read ahead at the next pointer so the byte is ready for the first bit
  swe_ram #(
    .Width (8),
    .Depth (MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (shift_in_q),
    .raddr_i (ptr_d),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      drive_q <= drive_d;
      dlev_q  <= dlev_d;
      hold_q  <= hold_d;
      bus_q   <= bus_code(mode_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign drive_level_o = dlev_q;
  assign hold_us_o     = hold_q;
  assign bus_mode_o    = bus_q;

endmodule

// File: rtl/swe_ram.sv
// ----------------------------------------------------------------------------
// swe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/swe_checker.sv
// ----------------------------------------------------------------------------
// swe_checker
// Port-level checks on the single-wire EEPROM slave results.
// ----------------------------------------------------------------------------
module swe_checker import swe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       drive_o,
  input logic       drive_level_o,
  input logic [2:0] hold_us_o,
  input logic [2:0] bus_mode_o
);

  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_o |-> drive_level_o && (hold_us_o == HoldNone))
    else $error("released line carries a hold time");

  a_drive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_o |->
      (hold_us_o == HoldDisc) || (hold_us_o == HoldAck) || (hold_us_o == HoldBit))
    else $error("driven line without a valid hold time");

  a_disc_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hold_us_o == HoldDisc) |->
      (bus_mode_o == BusIdle) && drive_o && !drive_level_o)
    else $error("discovery answer not followed by idle");

  a_bit_in_dout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hold_us_o == HoldBit) |-> (bus_mode_o == BusDout))
    else $error("data bit sent outside data-out mode");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_o) && $stable(drive_level_o) &&
      $stable(hold_us_o) && $stable(bus_mode_o))
    else $error("stalled item changed");

endmodule

bind single_wire_eeprom_slave swe_checker u_swe_checker (.*);

// File: dv/tb_single_wire_eeprom_slave.sv
// ----------------------------------------------------------------------------
// tb_single_wire_eeprom_slave
// Drives line edges into the single-wire EEPROM slave and checks every
// response against a cycle-free model of the bus protocol kept in the bench.
// Covers pulse decoding, discovery, command/address/data bytes, read-out and
// several timing and chip-address settings under sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_single_wire_eeprom_slave;
  import swe_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic       drive;
    logic       level;
    logic [2:0] hold;
    logic [2:0] mode;
  } line_resp_t;

  logic              clk_i;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              new_level  = 1'b0;
  logic [DurW-1:0]   duration   = '0;
  logic              out_ready  = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DurW-1:0]   cfg_data   = '0;
  logic              in_ready, out_valid;
  logic              drive, drive_level;
  logic [2:0]        hold_us, bus_mode;
  logic              cfg_ready;

  single_wire_eeprom_slave dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .new_level_i  (new_level),
    .duration_i   (duration),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .drive_o      (drive),
    .drive_level_o(drive_level),
    .hold_us_o    (hold_us),
    .bus_mode_o   (bus_mode),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // timing thresholds and chip address as the slave should hold them
  logic [DurW-1:0]  thr_start, thr_reset, thr_one_lo, thr_one_hi, thr_zero_lo, thr_zero_hi;
  logic [2:0]       my_chip;

  // protocol state of the slave
  logic [2:0]       bus_state;
  logic [3:0]       bits_in;
  logic [7:0]       rx_shift, tx_shift, cmd_byte;
  logic [1:0]       byte_pos;
  logic [AddrW-1:0] mem_ptr;
  logic [7:0]       eeprom [MemDepth];

  line_resp_t       expected_resp [$];
  int unsigned      n_sent, n_checked, n_errors;
  int unsigned      tx_idle_pct, rx_stall_pct;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic logic take_byte(input logic [7:0] b);
    if (byte_pos == 2'd0) begin
      cmd_byte = b;
      if (b[3:1] == my_chip) begin
        if (b[0]) bus_state = BusDout;
        if (b[7:4] == OpcodeEeprom) begin
          byte_pos = 2'd1;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (byte_pos == 2'd1) begin
      if (int'(b) < MemDepth) begin
        mem_ptr  = b[AddrW-1:0];
        byte_pos = 2'd2;
        return 1'b1;
      end
      return 1'b0;
    end
    eeprom[mem_ptr] = b;
    mem_ptr = mem_ptr + 1'b1;
    return 1'b1;
  endfunction

  function automatic line_resp_t predict_line_response(input logic lvl,
                                                       input logic [DurW-1:0] d);
    line_resp_t r;
    logic       one, zero, ack;
    r.drive = 1'b0;
    r.level = 1'b1;
    r.hold  = HoldNone;
    if (!lvl) begin
      if (d > thr_start) bus_state = BusIdle;
    end else if (d > thr_reset) begin
      bits_in   = '0;
      rx_shift  = '0;
      bus_state = BusDisc;
    end else begin
      one  = (thr_one_lo < d) && (d < thr_one_hi);
      zero = (thr_zero_lo < d) && (d < thr_zero_hi);
      case (bus_state)
        BusDisc: begin
          if (one) begin
            r.drive   = 1'b1;
            r.level   = 1'b0;
            r.hold    = HoldDisc;
            bus_state = BusIdle;
          end
        end
        BusIdle, BusDin: begin
          if (bus_state == BusIdle) begin
            byte_pos  = '0;
            bits_in   = '0;
            cmd_byte  = '0;
            rx_shift  = '0;
            tx_shift  = '0;
            bus_state = BusDin;
          end
          if ((one || zero) && bits_in < 4'd8) begin
            rx_shift = {rx_shift[6:0], one};
            bits_in  = bits_in + 4'd1;
          end else if (bits_in == 4'd8) begin
            ack      = take_byte(rx_shift);
            rx_shift = '0;
            r.drive  = 1'b1;
            r.level  = !ack;
            r.hold   = HoldAck;
            bits_in  = '0;
          end
        end
        BusDout: begin
          if (bits_in < 4'd8) begin
            if (bits_in == 4'd0 && cmd_byte[7:4] == OpcodeEeprom) begin
              tx_shift = eeprom[mem_ptr];
              mem_ptr  = mem_ptr + 1'b1;
            end
            r.drive  = 1'b1;
            r.level  = tx_shift[7];
            r.hold   = HoldBit;
            bits_in  = bits_in + 4'd1;
            tx_shift = {tx_shift[6:0], 1'b0};
          end else if (bits_in == 4'd8) begin
            if (one) bus_state = BusIdle;
            bits_in = '0;
          end
        end
        default: ;
      endcase
    end
    r.mode = bus_state;
    return r;
  endfunction

  initial begin
    thr_start   = StartHighMinRst;
    thr_reset   = ResetLowMinRst;
    thr_one_lo  = OneLowMinRst;
    thr_one_hi  = OneLowMaxRst;
    thr_zero_lo = ZeroLowMinRst;
    thr_zero_hi = ZeroLowMaxRst;
    my_chip     = '0;
    bus_state   = BusReset;
    bits_in     = '0;
    rx_shift    = '0;
    tx_shift    = '0;
    cmd_byte    = '0;
    byte_pos    = '0;
    mem_ptr     = '0;
    for (int i = 0; i < MemDepth; i++) eeprom[i] = EraseByte;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    line_resp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_resp.pop_front();
          if (drive !== want.drive)
            report_mismatch($sformatf("item %0d drive %b, want %b", n_checked, drive,
                                      want.drive));
          if (drive_level !== want.level)
            report_mismatch($sformatf("item %0d drive_level %b, want %b", n_checked,
                                      drive_level, want.level));
          if (hold_us !== want.hold)
            report_mismatch($sformatf("item %0d hold_us %0d, want %0d", n_checked, hold_us,
                                      want.hold));
          if (bus_mode !== want.mode)
            report_mismatch($sformatf("item %0d bus_mode %0d, want %0d", n_checked,
                                      bus_mode, want.mode));
          n_checked++;
        end
      end
      if (in_valid && in_ready)
        expected_resp.push_back(predict_line_response(new_level, duration));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgStartHighMin: thr_start   = cfg_data;
          CfgResetLowMin:  thr_reset   = cfg_data;
          CfgOneLowMin:    thr_one_lo  = cfg_data;
          CfgOneLowMax:    thr_one_hi  = cfg_data;
          CfgZeroLowMin:   thr_zero_lo = cfg_data;
          CfgZeroLowMax:   thr_zero_hi = cfg_data;
          CfgChipAddress:  my_chip     = cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // valid stays high after an item; drain_results or a gap drops it
  task automatic send_edge(input logic lvl, input logic [DurW-1:0] d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    new_level <= lvl;
    duration  <= d;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [DurW-1:0] start_min, reset_min, one_lo, one_hi,
                              zero_lo, zero_hi, chip);
    drain_results();
    write_reg(CfgStartHighMin, start_min);
    write_reg(CfgResetLowMin, reset_min);
    write_reg(CfgOneLowMin, one_lo);
    write_reg(CfgOneLowMax, one_hi);
    write_reg(CfgZeroLowMin, zero_lo);
    write_reg(CfgZeroLowMax, zero_hi);
    write_reg(CfgChipAddress, chip);
  endtask

  function automatic logic [DurW-1:0] dur_between(input logic [DurW-1:0] lo, hi);
    if (int'(hi) > int'(lo) + 1) return DurW'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return DurW'($urandom);
  endfunction

  function automatic logic [DurW-1:0] dur_above(input logic [DurW-1:0] lo);
    if (lo != '1) return DurW'($urandom_range(int'(lo) + 1, (1 << DurW) - 1));
    return '1;
  endfunction

  function automatic logic [DurW-1:0] dur_short_high();
    return DurW'($urandom_range(0, (thr_start > 400) ? 400 : int'(thr_start)));
  endfunction

  task automatic send_bit(input logic b);
    send_edge(1'b0, dur_short_high());
    send_edge(1'b1, b ? dur_between(thr_one_lo, thr_one_hi)
                      : dur_between(thr_zero_lo, thr_zero_hi));
  endtask

  // eight data pulses, then the acknowledge pulse
  task automatic send_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) send_bit(v[i]);
    send_bit(1'($urandom_range(0, 1)));
  endtask

  task automatic bus_reset(input logic with_presence);
    send_edge(1'b0, dur_short_high());
    send_edge(1'b1, dur_above(thr_reset));
    if (with_presence) send_bit(1'b1);
  endtask

  task automatic read_bytes(input int n);
    for (int k = 0; k < n; k++) begin
      repeat (8) send_bit(1'b1);
      send_bit(k == n - 1);
    end
  endtask

  task automatic random_transaction();
    int         kind;
    logic [7:0] cmd, addr;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) drain_results();
    if (kind < 8) begin
      repeat ($urandom_range(1, 6))
        send_edge(1'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 1) ? DurW'($urandom)
                                              : DurW'($urandom_range(0, 3000)));
    end else if (kind < 14) begin
      bus_reset(1'($urandom_range(0, 1)));
    end else begin
      if ($urandom_range(0, 4) == 0) bus_reset(1'b1);
      send_edge(1'b0, dur_above(thr_start));
      cmd[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : OpcodeEeprom;
      cmd[3:1] = ($urandom_range(0, 7) == 0) ? 3'($urandom) : my_chip;
      cmd[0]   = 1'($urandom_range(0, 1));
      send_byte(cmd);
      if (cmd[0]) begin
        read_bytes($urandom_range(1, 4));
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 7)) send_bit(1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    addr = 8'($urandom);
          2, 3, 4: addr = 8'($urandom_range(MemDepth - 8, MemDepth - 1));
          default: addr = 8'($urandom_range(0, MemDepth - 1));
        endcase
        send_byte(addr);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_line_events();
    send_edge(1'b1, 20'd0);
    send_edge(1'b1, 20'd300);
    send_edge(1'b0, 20'd0);
    send_edge(1'b1, 20'hFFFFF);
    send_edge(1'b0, 20'd100);
    send_edge(1'b1, 20'd2000);
    send_edge(1'b1, 20'd5000);
    send_edge(1'b1, 20'd200);
    send_edge(1'b0, 20'hFFFFF);
    send_edge(1'b0, 20'd50);
    send_edge(1'b1, 20'd5000);
    send_edge(1'b1, 20'd169);
    send_edge(1'b1, 20'd335);
    send_edge(1'b1, 20'd168);
    send_edge(1'b1, 20'd336);
    send_edge(1'b1, 20'd1009);
    send_edge(1'b1, 20'd2687);
    send_edge(1'b1, 20'd1008);
    send_edge(1'b1, 20'd2688);
    send_edge(1'b1, 20'd25200);
    send_edge(1'b1, 20'd25201);
    send_edge(1'b1, 20'd200);
    drain_results();
  endtask

  task automatic run_traffic(input int unsigned tx_pct, rx_pct, count);
    int unsigned target;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target       = n_sent + count;
    while (n_sent < target) random_transaction();
  endtask

  initial begin
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_line_events();
    run_traffic(0, 0, 150);

    write_timing(20'd1000, 20'd500, 20'd10, 20'd40, 20'd60, 20'd200, 20'($urandom_range(0, 7)));
    run_traffic(52, 0, 150);

    // overlapping one and zero windows; chip address from a full-width word
    write_timing(20'd3000, 20'd1500, 20'd50, 20'd300, 20'd100, 20'd400, 20'hFFFFF);
    run_traffic(0, 52, 150);

    write_timing(20'd0, 20'hFFFFE, 20'd0, 20'd3, 20'd2, 20'hFFFFE, 20'd0);
    write_reg(CfgUnused, 20'($urandom));
    run_traffic(21, 21, 150);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (expected_resp.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_resp.size()));
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
